// File: rtl/core/tclr_pkg.sv
package tclr_pkg;

   // Datapath sizes
   localparam int LEVEL_BITS  = 12;
   localparam int LENGTH_BITS = 8;
   localparam int NUM_CH      = 3;
   localparam int CH_W        = 2;
   localparam int CNT_W       = $clog2(LEVEL_BITS + 1);

   localparam logic [LEVEL_BITS-1:0] LEVEL_RESET = LEVEL_BITS'(32'h400);
   localparam logic [LEVEL_BITS-1:0] LEVEL_MAX   = {LEVEL_BITS{1'b1}};
   localparam logic [CNT_W-1:0]      CNT_LAST    = CNT_W'(LEVEL_BITS - 1);

   // Commands
   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_FORCE = 2'd2;

   // Channels
   localparam logic [CH_W-1:0] CH_TEMPO  = 2'd0;
   localparam logic [CH_W-1:0] CH_PITCH  = 2'd1;
   localparam logic [CH_W-1:0] CH_VOLUME = 2'd2;

   // Micro-operations
   localparam int OP_W = 3;
   localparam logic [OP_W-1:0] OP_WAIT     = 3'd0;
   localparam logic [OP_W-1:0] OP_ADVANCE  = 3'd1;
   localparam logic [OP_W-1:0] OP_TICK_END = 3'd2;
   localparam logic [OP_W-1:0] OP_DIV_INIT = 3'd3;
   localparam logic [OP_W-1:0] OP_DIV_STEP = 3'd4;
   localparam logic [OP_W-1:0] OP_DIV_END  = 3'd5;
   localparam logic [OP_W-1:0] OP_FORCE    = 3'd6;
   localparam logic [OP_W-1:0] OP_RESULT   = 3'd7;

   // Sequencing conditions
   localparam int COND_W = 3;
   localparam logic [COND_W-1:0] COND_NEXT     = 3'd0;
   localparam logic [COND_W-1:0] COND_JUMP     = 3'd1;
   localparam logic [COND_W-1:0] COND_DISPATCH = 3'd2;
   localparam logic [COND_W-1:0] COND_LOOP     = 3'd3;
   localparam logic [COND_W-1:0] COND_OUT_FREE = 3'd4;

   // Program addresses
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_WAIT     = 4'd0;
   localparam logic [STEP_W-1:0] STEP_TICK0    = 4'd1;
   localparam logic [STEP_W-1:0] STEP_TICK1    = 4'd2;
   localparam logic [STEP_W-1:0] STEP_TICK2    = 4'd3;
   localparam logic [STEP_W-1:0] STEP_TICK_END = 4'd4;
   localparam logic [STEP_W-1:0] STEP_DIV_INIT = 4'd5;
   localparam logic [STEP_W-1:0] STEP_DIV_STEP = 4'd6;
   localparam logic [STEP_W-1:0] STEP_DIV_END  = 4'd7;
   localparam logic [STEP_W-1:0] STEP_FORCE    = 4'd8;
   localparam logic [STEP_W-1:0] STEP_RESULT   = 4'd9;

   typedef struct packed {
      logic [1:0]             command;
      logic [CH_W-1:0]        channel_select;
      logic [LEVEL_BITS-1:0]  goal_value;
      logic [LENGTH_BITS-1:0] ramp_length;
   } req_type;

   typedef struct packed {
      logic [LEVEL_BITS-1:0] tempo_level;
      logic [LEVEL_BITS-1:0] pitch_level;
      logic [LEVEL_BITS-1:0] volume_level;
      logic                  ramp_active;
      logic                  all_reached;
   } rsp_type;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [COND_W-1:0] cond;
      logic [CH_W-1:0]   chan;
      logic [STEP_W-1:0] target;
   } ctl_word_type;

   // Microprogram
   function automatic ctl_word_type ucode_rom(input logic [STEP_W-1:0] addr);
      ctl_word_type w;
      w = '{op: OP_WAIT, cond: COND_JUMP, chan: CH_TEMPO, target: STEP_WAIT};
      case (addr)
         STEP_WAIT:
            w = '{op: OP_WAIT, cond: COND_DISPATCH, chan: CH_TEMPO, target: STEP_WAIT};
         STEP_TICK0:
            w = '{op: OP_ADVANCE, cond: COND_NEXT, chan: CH_TEMPO, target: STEP_WAIT};
         STEP_TICK1:
            w = '{op: OP_ADVANCE, cond: COND_NEXT, chan: CH_PITCH, target: STEP_WAIT};
         STEP_TICK2:
            w = '{op: OP_ADVANCE, cond: COND_NEXT, chan: CH_VOLUME, target: STEP_WAIT};
         STEP_TICK_END:
            w = '{op: OP_TICK_END, cond: COND_JUMP, chan: CH_TEMPO, target: STEP_RESULT};
         STEP_DIV_INIT:
            w = '{op: OP_DIV_INIT, cond: COND_NEXT, chan: CH_TEMPO, target: STEP_WAIT};
         STEP_DIV_STEP:
            w = '{op: OP_DIV_STEP, cond: COND_LOOP, chan: CH_TEMPO, target: STEP_DIV_STEP};
         STEP_DIV_END:
            w = '{op: OP_DIV_END, cond: COND_JUMP, chan: CH_TEMPO, target: STEP_RESULT};
         STEP_FORCE:
            w = '{op: OP_FORCE, cond: COND_NEXT, chan: CH_TEMPO, target: STEP_WAIT};
         STEP_RESULT:
            w = '{op: OP_RESULT, cond: COND_OUT_FREE, chan: CH_TEMPO, target: STEP_WAIT};
         default:
            w = '{op: OP_WAIT, cond: COND_JUMP, chan: CH_TEMPO, target: STEP_WAIT};
      endcase
      return w;
   endfunction

endpackage

// File: rtl/core/three_channel_linear_ramp_unit.sv
// Three-channel linear ramp unit (tempo, pitch, volume). Each request transaction yields
// exactly one response transaction carrying all three levels, the active flag and the
// all-reached flag. Start ramp computes a per-tick stride with a restoring divider that
// produces one quotient bit per cycle. One request is processed at a time; the next is
// taken as soon as the program returns to its wait step, while the previous response
// may still be waiting in the output register. Levels reset to 0x400, goals and
// strides to zero, idle.
module three_channel_linear_ramp_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tclr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tclr_pkg::rsp_type rsp_data
);
   import tclr_pkg::*;

   // ---------------------------------------------------------------
   // Sequencer state
   // ---------------------------------------------------------------
   logic [STEP_W-1:0] pc_ff, pc_in;
   ctl_word_type      ctl;

   // Latched request
   req_type req_ff, req_in;

   // Channel state
   logic        [LEVEL_BITS-1:0] level_ff  [0:NUM_CH-1];
   logic        [LEVEL_BITS-1:0] level_in  [0:NUM_CH-1];
   logic        [LEVEL_BITS-1:0] goal_ff   [0:NUM_CH-1];
   logic        [LEVEL_BITS-1:0] goal_in   [0:NUM_CH-1];
   logic signed [LEVEL_BITS:0]   stride_ff [0:NUM_CH-1];
   logic signed [LEVEL_BITS:0]   stride_in [0:NUM_CH-1];
   logic                         active_ff, active_in;
   logic                         reached_ff, reached_in;
   logic        [NUM_CH-1:0]     hit_ff, hit_in;

   // Divider state
   logic [LEVEL_BITS-1:0]  quo_ff, quo_in;
   logic [LENGTH_BITS-1:0] rem_ff, rem_in;
   logic [LENGTH_BITS-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   neg_ff, neg_in;
   logic                   zero_ff, zero_in;

   // Output register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   // ---------------------------------------------------------------
   // Datapath
   // ---------------------------------------------------------------
   logic [CH_W-1:0]              sel_ch;
   logic        [LEVEL_BITS-1:0] sel_level;
   logic        [LEVEL_BITS-1:0] sel_goal;
   logic signed [LEVEL_BITS:0]   sel_stride;

   // tick advance
   logic signed [LEVEL_BITS:0]   adv_diff;
   logic        [LEVEL_BITS:0]   adv_diff_mag;
   logic        [LEVEL_BITS:0]   adv_stride_mag;
   logic                         adv_hit;
   logic signed [LEVEL_BITS+1:0] adv_sum;
   logic        [LEVEL_BITS-1:0] adv_next;

   // divider
   logic signed [LEVEL_BITS:0]    off;
   logic        [LEVEL_BITS:0]    off_abs;
   logic        [LENGTH_BITS:0]   div_shift;
   logic        [LENGTH_BITS+1:0] div_trial;
   logic                          div_bit;
   logic signed [LEVEL_BITS:0]    stride_new;

   logic out_free;
   logic [STEP_W-1:0] dispatch_step;

   assign ctl      = ucode_rom(pc_ff);
   assign sel_ch   = (ctl.op == OP_ADVANCE) ? ctl.chan : req_ff.channel_select;
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign sel_level  = level_ff[sel_ch];
   assign sel_goal   = goal_ff[sel_ch];
   assign sel_stride = stride_ff[sel_ch];

   // Snap when within one stride, else step with saturation
   assign adv_diff       = $signed({1'b0, sel_level}) - $signed({1'b0, sel_goal});
   assign adv_diff_mag   = adv_diff[LEVEL_BITS] ? (LEVEL_BITS + 1)'(-adv_diff)
                                                : (LEVEL_BITS + 1)'(adv_diff);
   assign adv_stride_mag = sel_stride[LEVEL_BITS] ? (LEVEL_BITS + 1)'(-sel_stride)
                                                  : (LEVEL_BITS + 1)'(sel_stride);
   assign adv_hit        = adv_diff_mag <= adv_stride_mag;
   assign adv_sum        = $signed({2'b00, sel_level}) + (LEVEL_BITS + 2)'(sel_stride);

   always_comb begin
      if (adv_hit) begin
         adv_next = sel_goal;
      end else if (adv_sum[LEVEL_BITS+1]) begin
         adv_next = '0;
      end else if (adv_sum[LEVEL_BITS]) begin
         adv_next = LEVEL_MAX;
      end else begin
         adv_next = adv_sum[LEVEL_BITS-1:0];
      end
   end

   // Offset to goal, magnitude divided by the length
   assign off     = $signed({1'b0, req_ff.goal_value}) - $signed({1'b0, sel_level});
   assign off_abs = off[LEVEL_BITS] ? (LEVEL_BITS + 1)'(-off) : (LEVEL_BITS + 1)'(off);

   // One restoring step
   assign div_shift = {rem_ff, quo_ff[LEVEL_BITS-1]};
   assign div_trial = {1'b0, div_shift} - {2'b00, dvs_ff};
   assign div_bit   = !div_trial[LENGTH_BITS+1];

   // Sign the quotient; a zero quotient becomes the sign of the offset
   always_comb begin
      if (quo_ff == '0) begin
         if (zero_ff) begin
            stride_new = '0;
         end else if (neg_ff) begin
            stride_new = '1;
         end else begin
            stride_new = (LEVEL_BITS + 1)'(1);
         end
      end else if (neg_ff) begin
         stride_new = -$signed({1'b0, quo_ff});
      end else begin
         stride_new = $signed({1'b0, quo_ff});
      end
   end

   // Program entry for the incoming command
   always_comb begin
      case (req_data.command)
         CMD_TICK:
            dispatch_step = active_ff ? STEP_TICK0 : STEP_RESULT;
         CMD_START:
            dispatch_step = (req_data.channel_select < CH_W'(NUM_CH)) ? STEP_DIV_INIT
                                                                      : STEP_RESULT;
         CMD_FORCE:
            dispatch_step = (req_data.channel_select < CH_W'(NUM_CH)) ? STEP_FORCE
                                                                      : STEP_RESULT;
         default:
            dispatch_step = STEP_RESULT;
      endcase
   end

   assign req_ready = (ctl.op == OP_WAIT);

   // ---------------------------------------------------------------
   // Control word execution
   // ---------------------------------------------------------------
   always_comb begin
      req_in       = req_ff;
      level_in     = level_ff;
      goal_in      = goal_ff;
      stride_in    = stride_ff;
      active_in    = active_ff;
      reached_in   = reached_ff;
      hit_in       = hit_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      dvs_in       = dvs_ff;
      cnt_in       = cnt_ff;
      neg_in       = neg_ff;
      zero_in      = zero_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (ctl.op)
         OP_WAIT: begin
            if (req_valid) begin
               req_in     = req_data;
               reached_in = 1'b0;
            end
         end
         OP_ADVANCE: begin
            level_in[sel_ch] = adv_next;
            hit_in[sel_ch]   = adv_hit;
         end
         OP_TICK_END: begin
            if (&hit_ff) begin
               active_in  = 1'b0;
               reached_in = 1'b1;
            end
         end
         OP_DIV_INIT: begin
            quo_in  = off_abs[LEVEL_BITS-1:0];
            rem_in  = '0;
            dvs_in  = (req_ff.ramp_length == '0) ? LENGTH_BITS'(1) : req_ff.ramp_length;
            cnt_in  = '0;
            neg_in  = off[LEVEL_BITS];
            zero_in = (off == '0);
         end
         OP_DIV_STEP: begin
            quo_in = {quo_ff[LEVEL_BITS-2:0], div_bit};
            rem_in = div_bit ? div_trial[LENGTH_BITS-1:0] : div_shift[LENGTH_BITS-1:0];
            cnt_in = cnt_ff + 1'b1;
         end
         OP_DIV_END: begin
            stride_in[sel_ch] = stride_new;
            goal_in[sel_ch]   = req_ff.goal_value;
            active_in         = 1'b1;
         end
         OP_FORCE: begin
            level_in[sel_ch] = req_ff.goal_value;
         end
         OP_RESULT: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.tempo_level  = level_ff[CH_TEMPO];
               rsp_in.pitch_level  = level_ff[CH_PITCH];
               rsp_in.volume_level = level_ff[CH_VOLUME];
               rsp_in.ramp_active  = active_ff;
               rsp_in.all_reached  = reached_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // Step counter
   always_comb begin
      unique case (ctl.cond)
         COND_NEXT:     pc_in = pc_ff + 1'b1;
         COND_JUMP:     pc_in = ctl.target;
         COND_DISPATCH: pc_in = req_valid ? dispatch_step : pc_ff;
         COND_LOOP:     pc_in = (cnt_ff != CNT_LAST) ? ctl.target : pc_ff + 1'b1;
         COND_OUT_FREE: pc_in = out_free ? ctl.target : pc_ff;
         default:       pc_in = STEP_WAIT;
      endcase
   end

   // ---------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= STEP_WAIT;
         active_ff    <= 1'b0;
         reached_ff   <= 1'b0;
         hit_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_CH; i++) begin
            level_ff[i]  <= LEVEL_RESET;
            goal_ff[i]   <= '0;
            stride_ff[i] <= '0;
         end
      end else begin
         pc_ff        <= pc_in;
         active_ff    <= active_in;
         reached_ff   <= reached_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
         level_ff     <= level_in;
         goal_ff      <= goal_in;
         stride_ff    <= stride_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      cnt_ff  <= cnt_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous still in progress");

   a_reached_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.all_reached |-> !rsp_ff.ramp_active)
      else $error("all_reached reported while still active");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      pc_ff == STEP_DIV_STEP |-> cnt_ff <= CNT_LAST)
      else $error("divider step count overran");

   a_stride_nonzero: assert property (@(posedge clock) disable iff (reset)
      pc_ff == STEP_DIV_END && !zero_ff |=> stride_ff[req_ff.channel_select] != '0)
      else $error("zero stride for a non-zero offset");

   a_result_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("response register lost a pending transaction");

endmodule

// File: sim/three_channel_linear_ramp_checker.sv
// Watches the request and response channels of the ramp unit, keeps its own copy of the levels,
// goals and strides, and compares every response transaction with the
// oldest outstanding prediction.
module three_channel_linear_ramp_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  tclr_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  tclr_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                pending,
   output int                checked_count,
   output int                reached_count
);
   import tclr_pkg::*;

   localparam int REPORT_CAP = 40;

   rsp_type due_levels_q[$];
   rsp_type want, made;

   logic        [LEVEL_BITS-1:0] level_m  [NUM_CH];
   logic        [LEVEL_BITS-1:0] goal_m   [NUM_CH];
   logic signed [LEVEL_BITS:0]   stride_m [NUM_CH];
   logic                         ramping;

   int fails;
   int checked;
   int reached;

   initial begin
      fails   = 0;
      checked = 0;
      reached = 0;
   end

   task automatic clear_ramps();
      int c;
      for (c = 0; c < NUM_CH; c++) begin
         level_m[c]  = LEVEL_RESET;
         goal_m[c]   = '0;
         stride_m[c] = '0;
      end
      ramping = 1'b0;
   endtask

   // Applies one request to the local copy and returns the response it causes.
   task automatic step_ramps(input req_type r, output rsp_type e);
      int   c, lvl, gl, st, nxt, ofs, len, q;
      logic all_done, hit;
      hit = 1'b0;
      if (r.command == CMD_TICK) begin
         if (ramping) begin
            all_done = 1'b1;
            for (c = 0; c < NUM_CH; c++) begin
               lvl = int'(level_m[c]);
               gl  = int'(goal_m[c]);
               st  = int'(stride_m[c]);
               if (((lvl > gl) ? lvl - gl : gl - lvl) <= ((st < 0) ? -st : st)) begin
                  level_m[c] = goal_m[c];
               end else begin
                  nxt = lvl + st;
                  if (nxt < 0) nxt = 0;
                  if (nxt > int'(LEVEL_MAX)) nxt = int'(LEVEL_MAX);
                  level_m[c] = nxt[LEVEL_BITS-1:0];
                  all_done   = 1'b0;
               end
            end
            if (all_done) begin
               ramping = 1'b0;
               hit     = 1'b1;
            end
         end
      end else if (r.command == CMD_START && r.channel_select < NUM_CH) begin
         ofs = int'(r.goal_value) - int'(level_m[r.channel_select]);
         len = (r.ramp_length == '0) ? 1 : int'(r.ramp_length);
         q   = ofs / len;
         if (q == 0) q = (ofs > 0) ? 1 : ((ofs < 0) ? -1 : 0);
         stride_m[r.channel_select] = q[LEVEL_BITS:0];
         goal_m[r.channel_select]   = r.goal_value;
         ramping                    = 1'b1;
      end else if (r.command == CMD_FORCE && r.channel_select < NUM_CH) begin
         level_m[r.channel_select] = r.goal_value;
      end
      e.tempo_level  = level_m[CH_TEMPO];
      e.pitch_level  = level_m[CH_PITCH];
      e.volume_level = level_m[CH_VOLUME];
      e.ramp_active  = ramping;
      e.all_reached  = hit;
   endtask

   task automatic compare_field(input string name, input logic [LEVEL_BITS-1:0] exp_v,
                                input logic [LEVEL_BITS-1:0] got_v);
      if (got_v !== exp_v) begin
         fails++;
         if (fails <= REPORT_CAP)
            $display("%0t mismatch on %s: expected %0d, got %0d", $time, name, exp_v, got_v);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_ramps();
         due_levels_q.delete();
      end else begin
         // response first: it always belongs to an earlier request
         if (rsp_valid && rsp_ready) begin
            if (due_levels_q.size() == 0) begin
               fails++;
               if (fails <= REPORT_CAP)
                  $display("%0t response with nothing outstanding: expected none, got %h",
                           $time, rsp_data);
            end else begin
               want = due_levels_q.pop_front();
               checked++;
               compare_field("tempo_level",  want.tempo_level,  rsp_data.tempo_level);
               compare_field("pitch_level",  want.pitch_level,  rsp_data.pitch_level);
               compare_field("volume_level", want.volume_level, rsp_data.volume_level);
               compare_field("ramp_active",  LEVEL_BITS'(want.ramp_active),
                             LEVEL_BITS'(rsp_data.ramp_active));
               compare_field("all_reached",  LEVEL_BITS'(want.all_reached),
                             LEVEL_BITS'(rsp_data.all_reached));
            end
         end
         if (req_valid && req_ready) begin
            step_ramps(req_data, made);
            due_levels_q.push_back(made);
            if (made.all_reached) reached++;
         end
      end
      fail_count    <= fails;
      pending       <= due_levels_q.size();
      checked_count <= checked;
      reached_count <= reached;
   end

endmodule

// File: sim/tb_three_channel_linear_ramp_unit.sv
// Stimulus and verdict for the ramp unit; all prediction lives in the checker.
module tb_three_channel_linear_ramp_unit;
   import tclr_pkg::*;

   // Codes the block must ignore
   localparam logic [1:0]      CMD_NONE = 2'd3;
   localparam logic [CH_W-1:0] CH_NONE  = 2'd3;

   // Receiver stall patterns
   localparam int RX_OPEN  = 0;   // always ready
   localparam int RX_COIN  = 1;   // ready half the time
   localparam int RX_LONG  = 2;   // long stalls, short openings
   localparam int RX_LIGHT = 3;   // ready three quarters of the time

   localparam int TARGET_ITEMS = 1250;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 40;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   int fail_count;
   int pending;
   int checked_count;
   int reached_count;

   req_type stim_q[$];
   int      live_items;
   int      cycles;

   three_channel_linear_ramp_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   three_channel_linear_ramp_checker ramp_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending       (pending),
      .checked_count (checked_count),
      .reached_count (reached_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // --------------------------------------------------------------------
   // Stimulus construction
   // --------------------------------------------------------------------
   task automatic add_item(input logic [1:0] cmd, input logic [CH_W-1:0] ch,
                           input logic [LEVEL_BITS-1:0] goal,
                           input logic [LENGTH_BITS-1:0] len);
      req_type r;
      r.command        = cmd;
      r.channel_select = ch;
      r.goal_value     = goal;
      r.ramp_length    = len;
      stim_q.push_back(r);
      // unused commands, and start/force on the spare channel, are ignored
      if (!(cmd == CMD_NONE || (cmd != CMD_TICK && ch == CH_NONE))) live_items++;
   endtask

   function automatic logic [LEVEL_BITS-1:0] pick_goal();
      int roll;
      roll = $urandom_range(0, 7);
      if (roll == 0) return '0;
      if (roll == 1) return LEVEL_MAX;
      return LEVEL_BITS'($urandom_range(0, 4095));
   endfunction

   // Mostly short ramps so that they finish; now and then the full range.
   function automatic logic [LENGTH_BITS-1:0] pick_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return LENGTH_BITS'($urandom_range(0, 8));
      if (roll < 95) return LENGTH_BITS'($urandom_range(0, 40));
      return LENGTH_BITS'($urandom_range(0, 255));
   endfunction

   task automatic build_stimulus();
      int kind, c, n;
      live_items = 0;

      // Directed: idle tick, ignored codes, extremes, all reached together
      add_item(CMD_TICK,  CH_TEMPO,  12'd0,    8'd0);
      add_item(CMD_NONE,  CH_PITCH,  12'd4095, 8'd255);
      add_item(CMD_START, CH_NONE,   12'd4095, 8'd255);
      add_item(CMD_FORCE, CH_NONE,   12'd0,    8'd0);
      add_item(CMD_FORCE, CH_TEMPO,  12'd0,    8'd0);
      add_item(CMD_FORCE, CH_PITCH,  12'd4095, 8'd0);
      add_item(CMD_START, CH_TEMPO,  12'd4095, 8'd0);
      add_item(CMD_START, CH_PITCH,  12'd0,    8'd3);
      add_item(CMD_START, CH_VOLUME, 12'd1024, 8'd7);
      add_item(CMD_TICK,  CH_TEMPO,  12'd0,    8'd0);
      add_item(CMD_TICK,  CH_VOLUME, 12'd4095, 8'd255);
      add_item(CMD_TICK,  CH_PITCH,  12'd0,    8'd0);
      // Quotient rounds to zero: stride of one upward
      add_item(CMD_START, CH_VOLUME, 12'd1025, 8'd200);
      add_item(CMD_START, CH_PITCH,  12'd1,    8'd255);
      // Force during a ramp
      add_item(CMD_FORCE, CH_VOLUME, 12'd0,    8'd0);
      add_item(CMD_TICK,  CH_TEMPO,  12'd0,    8'd0);
      // Stride pointing away after a force: clamps at both ends
      add_item(CMD_START, CH_TEMPO,  12'd3000, 8'd1);
      add_item(CMD_FORCE, CH_TEMPO,  12'd0,    8'd0);
      add_item(CMD_START, CH_PITCH,  12'd1000, 8'd1);
      add_item(CMD_FORCE, CH_PITCH,  12'd4095, 8'd0);
      add_item(CMD_TICK,  CH_TEMPO,  12'd0,    8'd0);
      add_item(CMD_TICK,  CH_TEMPO,  12'd0,    8'd0);
      // Recover the stuck channels, then finish together
      add_item(CMD_START, CH_TEMPO,  12'd0,    8'd0);
      add_item(CMD_START, CH_PITCH,  12'd4095, 8'd128);
      add_item(CMD_FORCE, CH_VOLUME, 12'd1025, 8'd0);
      add_item(CMD_TICK,  CH_TEMPO,  12'd0,    8'd0);

      // Random episodes, mostly well-formed ramp sequences
      while (live_items < TARGET_ITEMS) begin
         kind = $urandom_range(0, 9);
         if (kind <= 5) begin
            for (c = 0; c < NUM_CH; c++) begin
               if ($urandom_range(0, 3) != 0)
                  add_item(CMD_START, CH_W'(c), pick_goal(), pick_length());
               if ($urandom_range(0, 4) == 0)
                  add_item(CMD_FORCE, CH_W'($urandom_range(0, 2)), pick_goal(),
                           LENGTH_BITS'($urandom_range(0, 255)));
            end
            n = $urandom_range(1, 45);
            repeat (n) add_item(CMD_TICK, CH_W'($urandom_range(0, 3)),
                                LEVEL_BITS'($urandom_range(0, 4095)),
                                LENGTH_BITS'($urandom_range(0, 255)));
         end else if (kind == 6) begin
            n = $urandom_range(1, 4);
            repeat (n) add_item(CMD_FORCE, CH_W'($urandom_range(0, 2)), pick_goal(),
                                LENGTH_BITS'($urandom_range(0, 255)));
         end else if (kind == 7) begin
            n = $urandom_range(1, 8);
            repeat (n) add_item(2'($urandom_range(0, 3)), CH_W'($urandom_range(0, 3)),
                                LEVEL_BITS'($urandom_range(0, 4095)),
                                LENGTH_BITS'($urandom_range(0, 255)));
         end else if (kind == 8) begin
            // broken sequence: ignored codes mixed into a ramp
            add_item(CMD_START, CH_NONE, pick_goal(), pick_length());
            add_item(CMD_START, CH_W'($urandom_range(0, 2)), pick_goal(), pick_length());
            add_item(CMD_NONE, CH_W'($urandom_range(0, 3)), pick_goal(), pick_length());
            add_item(CMD_FORCE, CH_NONE, pick_goal(), pick_length());
            n = $urandom_range(1, 6);
            repeat (n) add_item(CMD_TICK, CH_TEMPO, 12'd0, 8'd0);
         end else begin
            n = $urandom_range(1, 10);
            repeat (n) add_item(CMD_TICK, CH_TEMPO, pick_goal(), pick_length());
         end
      end
   endtask

   // --------------------------------------------------------------------
   // Sender: bursts of transactions with random gaps; changes on the
   // falling edge, acceptance seen at the rising edge.
   // --------------------------------------------------------------------
   int burst_left;
   int gap_left;

   task automatic next_burst();
      if ($urandom_range(0, 9) == 0) begin
         burst_left = $urandom_range(30, 60);   // a stretch with no idling
         gap_left   = 0;
      end else begin
         burst_left = $urandom_range(1, 12);
         gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
      end
   endtask

   initial begin
      int idx;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      build_stimulus();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      idx      = 0;
      gap_left = 0;
      next_burst();
      while (idx < stim_q.size()) begin
         @(negedge clock);
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else begin
            req_valid <= 1'b1;
            req_data  <= stim_q[idx];
         end
         @(posedge clock);
         if (req_valid && req_ready) begin
            idx++;
            burst_left--;
            if (burst_left == 0) next_burst();
         end
      end
      @(negedge clock);
      req_valid <= 1'b0;

      // Drain: wait for every outstanding response, then a little longer
      // to catch anything spurious.
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("summary: %0d requests sent, %0d responses checked, %0d ramp sets completed",
               stim_q.size(), checked_count, reached_count);
      $display("summary: extremes, unused codes, forced saturation and random ramps under stalls");
      if (fail_count == 0 && pending == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d failures, %0d responses outstanding", fail_count, pending);
         $display("status: fail");
      end
      $finish;
   end

   // --------------------------------------------------------------------
   // Receiver: back-pressure whose pattern changes now and then
   // --------------------------------------------------------------------
   initial begin
      int   stall_mode, mode_left, run_left;
      logic run_high;
      rsp_ready  = 1'b0;
      stall_mode = RX_OPEN;
      mode_left  = 0;
      run_left   = 0;
      run_high   = 1'b0;
      forever begin
         @(negedge clock);
         if (mode_left == 0) begin
            stall_mode = $urandom_range(RX_OPEN, RX_LIGHT);
            mode_left  = $urandom_range(20, 300);
         end
         mode_left--;
         case (stall_mode)
            RX_OPEN: begin
               rsp_ready <= 1'b1;
            end
            RX_COIN: begin
               rsp_ready <= 1'($urandom_range(0, 1));
            end
            RX_LONG: begin
               if (run_left == 0) begin
                  run_high = ~run_high;
                  run_left = run_high ? $urandom_range(1, 4) : $urandom_range(1, 30);
               end
               run_left--;
               rsp_ready <= run_high;
            end
            default: begin
               rsp_ready <= ($urandom_range(0, 3) != 0);
            end
         endcase
      end
   end

   // Watchdog
   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("timeout after %0d cycles, %0d responses outstanding", cycles, pending);
      $display("status: fail");
      $finish;
   end

endmodule
